// ===== hdl/tcl_pkg.sv =====
// Shared types, constants and helpers of the text chunk locator.
`default_nettype none
package tcl_pkg;

   localparam int PosWidth   = 16;
   localparam int CountWidth = 17;

   localparam logic [PosWidth-1:0] MaxTextBytes = 16'hFFFF;

   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_WORD = 2'd1;
   localparam logic [1:0] KIND_ITEM = 2'd2;
   localparam logic [1:0] KIND_LINE = 2'd3;

   localparam logic [2:0] REG_CHUNK_KIND  = 3'd0;
   localparam logic [2:0] REG_DELIM_BYTES = 3'd1;
   localparam logic [2:0] REG_DELIM_LEN   = 3'd2;
   localparam logic [2:0] REG_FIRST_RANK  = 3'd3;
   localparam logic [2:0] REG_LAST_RANK   = 3'd4;

   localparam logic [7:0] ByteQuote    = 8'h22;
   localparam logic [7:0] ByteNewline  = 8'h0A;
   localparam logic [7:0] ByteComma    = 8'h2C;
   localparam logic [7:0] Utf8TopMask  = 8'hC0;
   localparam logic [7:0] Utf8ContCode = 8'h80;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_text;
   } tcl_req_type;

   typedef struct packed {
      logic [15:0] chunk_count;
      logic [15:0] start_offset;
      logic [15:0] end_offset;
      logic        found;
   } tcl_rsp_type;

   typedef struct packed {
      logic [1:0]  chunk_kind;
      logic [31:0] delimiter_bytes;
      logic [2:0]  delimiter_length;
      logic [15:0] first_rank;
      logic [15:0] last_rank;
   } tcl_cfg_type;

   // Scan state as it stands after the closing step at the end of text.
   typedef struct packed {
      logic [CountWidth-1:0] chunk_counter;
      logic [PosWidth-1:0]   text_length;
      logic [PosWidth-1:0]   first_start;
      logic [PosWidth-1:0]   first_end;
      logic                  first_found;
      logic [PosWidth-1:0]   last_start;
      logic [PosWidth-1:0]   last_end;
      logic                  last_found;
      logic                  lead_orphan;
      logic                  prev_newline;
   } tcl_scan_type;

   function automatic logic is_blank(input logic [7:0] b);
      return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) ||
             (b == 8'h0D) || (b == 8'h0B) || (b == 8'h0C);
   endfunction

endpackage
`default_nettype wire

// ===== hdl/text_chunk_locator_top.sv =====
// Top level of the text chunk locator: byte input, result output, configuration port.
//
// Text enters on the req_ channel one byte per transfer; a transfer with
// end_of_text set closes the text and yields exactly one result on the rsp_
// channel: the chunk count of the configured kind and the byte bounds of the
// range first_rank..last_rank. Byte transfers yield no result.
// Throughput is one transfer per cycle while no end-of-text transfer is held off;
// each of the first MaxTextBytes bytes updates the scan registers in the cycle it is
// taken. The result is registered and becomes valid in the cycle after the end-of-text transfer.
// While a result waits on rsp_ready, byte transfers keep being taken; only an
// end-of-text transfer is held off until the output register is free.
// Registers are written through the APB-style port at byte address 4*index. The user
// must write them only while no text is in flight; the block does not enforce this.
// Synchronous reset loads register defaults, clears all scan state and empties the
// output register. After each result the scan state alone returns to reset value.
`default_nettype none
module text_chunk_locator_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire tcl_pkg::tcl_req_type req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output tcl_pkg::tcl_rsp_type      rsp_payload,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [4:0]           paddr,
   input  wire logic [31:0]          pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   import tcl_pkg::*;

   tcl_cfg_type  cfg;
   tcl_scan_type view;
   logic         req_xfer, step, finish;

   // An end-of-text transfer needs room in the output register.
   assign req_ready = !req_payload.end_of_text || !rsp_valid || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign step      = req_xfer && !req_payload.end_of_text;
   assign finish    = req_xfer && req_payload.end_of_text;

   tcl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tcl_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (step),
      .finish    (finish),
      .data_byte (req_payload.data_byte),
      .view      (view)
   );

   tcl_result u_result (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .view        (view),
      .load        (finish),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

`ifndef NO_ASSERTIONS
   a_rsp_from_end : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_payload.end_of_text))
      else $error("result appeared without an end-of-text transfer");

   a_ready_low_only_stalled : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready && req_payload.end_of_text))
      else $error("input held off while the output register could take a result");

   a_end_with_full_output : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && req_valid && req_payload.end_of_text) |=> rsp_valid)
      else $error("stalled result was lost");
`endif

endmodule
`default_nettype wire

// ===== hdl/tcl_csr.sv =====
// Configuration registers of the text chunk locator behind an APB-style port.
`default_nettype none
module tcl_csr (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [4:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic [31:0]              prdata,
   output logic                     pready,
   output tcl_pkg::tcl_cfg_type     cfg
);
   import tcl_pkg::*;

   tcl_cfg_type cfg_ff, cfg_in;
   logic        wr_en;
   logic [2:0]  reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[4:2];
   assign wr_en     = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_CHUNK_KIND:  cfg_in.chunk_kind       = pwdata[1:0];
            REG_DELIM_BYTES: cfg_in.delimiter_bytes  = pwdata;
            REG_DELIM_LEN:   cfg_in.delimiter_length = pwdata[2:0];
            REG_FIRST_RANK:  cfg_in.first_rank       = pwdata[15:0];
            REG_LAST_RANK:   cfg_in.last_rank        = pwdata[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chunk_kind       <= KIND_CHAR;
         cfg_ff.delimiter_bytes  <= {24'd0, ByteComma};
         cfg_ff.delimiter_length <= 3'd1;
         cfg_ff.first_rank       <= 16'd1;
         cfg_ff.last_rank        <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_CHUNK_KIND:  prdata = {30'd0, cfg_ff.chunk_kind};
         REG_DELIM_BYTES: prdata = cfg_ff.delimiter_bytes;
         REG_DELIM_LEN:   prdata = {29'd0, cfg_ff.delimiter_length};
         REG_FIRST_RANK:  prdata = {16'd0, cfg_ff.first_rank};
         REG_LAST_RANK:   prdata = {16'd0, cfg_ff.last_rank};
         default:         prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== hdl/tcl_scan.sv =====
// Per-byte chunk tracking: counters, word state, delimiter window and range bounds.
`default_nettype none
module tcl_scan (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tcl_pkg::tcl_cfg_type cfg,
   input  wire logic                 step,
   input  wire logic                 finish,
   input  wire logic [7:0]           data_byte,
   output tcl_pkg::tcl_scan_type     view
);
   import tcl_pkg::*;

   localparam logic [1:0] WORD_BETWEEN = 2'd0;
   localparam logic [1:0] WORD_PLAIN   = 2'd1;
   localparam logic [1:0] WORD_QUOTED  = 2'd2;

   logic [PosWidth-1:0]   pos_ff, pos_in;
   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic [PosWidth-1:0]   cur_start_ff, cur_start_in;
   logic                  open_ff, open_in;
   logic                  orphan_ff, orphan_in;
   logic [PosWidth-1:0]   first_start_ff, first_start_in, first_end_ff, first_end_in;
   logic [PosWidth-1:0]   last_start_ff, last_start_in, last_end_ff, last_end_in;
   logic                  first_found_ff, first_found_in, last_found_ff, last_found_in;
   logic [1:0]            word_ff, word_in;
   logic [31:0]           window_ff, window_in;
   logic [2:0]            guard_ff, guard_in;
   logic                  prev_nl_ff, prev_nl_in;

   logic                  take_byte;
   logic                  blank, quote, newline, cont;
   logic [2:0]            dlen;
   logic [31:0]           dbytes;
   logic [2:0]            guard_inc;
   logic                  pattern_eq, hit;
   logic                  pre_open;
   logic [CountWidth-1:0] cnt1, cnt2;
   logic [PosWidth-1:0]   start1, start2;
   logic                  open1, open2;
   logic                  do_close, do_open, close_hit;
   logic [PosWidth-1:0]   close_pos, open_pos, pos_next;
   logic [1:0]            word_next;

   assign take_byte = step && (pos_ff != MaxTextBytes);
   assign blank     = is_blank(data_byte);
   assign quote     = (data_byte == ByteQuote);
   assign newline   = (data_byte == ByteNewline);
   assign cont      = ((data_byte & Utf8TopMask) == Utf8ContCode);
   assign pos_next  = pos_ff + 16'd1;

   // Delimiter length zero means a single comma; lengths above four count as four.
   always_comb begin
      if (cfg.delimiter_length == 3'd0) begin
         dlen   = 3'd1;
         dbytes = {24'd0, ByteComma};
      end else if (cfg.delimiter_length > 3'd4) begin
         dlen   = 3'd4;
         dbytes = cfg.delimiter_bytes;
      end else begin
         dlen   = cfg.delimiter_length;
         dbytes = cfg.delimiter_bytes;
      end
   end

   assign window_in = {data_byte, window_ff[31:8]};
   assign guard_inc = (guard_ff < 3'd7) ? guard_ff + 3'd1 : guard_ff;

   always_comb begin
      case (dlen)
         3'd1:    pattern_eq = (window_in[31:24] == dbytes[7:0]);
         3'd2:    pattern_eq = (window_in[31:16] == dbytes[15:0]);
         3'd3:    pattern_eq = (window_in[31:8] == dbytes[23:0]);
         default: pattern_eq = (window_in == dbytes);
      endcase
   end

   assign hit      = (guard_inc >= dlen) && pattern_eq;
   assign guard_in = hit ? 3'd0 : guard_inc;

   // Items and lines always have a chunk open once text is under way.
   assign pre_open = cfg.chunk_kind[1] && !open_ff;
   assign cnt1     = pre_open ? cnt_ff + 17'd1 : cnt_ff;
   assign start1   = pre_open ? pos_ff : cur_start_ff;
   assign open1    = open_ff || pre_open;

   always_comb begin
      do_close  = 1'b0;
      do_open   = 1'b0;
      close_pos = pos_ff;
      open_pos  = pos_ff;
      word_next = word_ff;
      if (finish) begin
         do_close = 1'b1;
      end else begin
         case (cfg.chunk_kind)
            KIND_CHAR: begin
               do_close = (pos_ff == 16'd0) || !cont;
               do_open  = do_close;
            end
            KIND_WORD: begin
               case (word_ff)
                  WORD_PLAIN: begin
                     if (blank) begin
                        do_close  = 1'b1;
                        word_next = WORD_BETWEEN;
                     end
                  end
                  WORD_QUOTED: begin
                     if (quote) begin
                        do_close  = 1'b1;
                        close_pos = pos_next;
                        word_next = WORD_BETWEEN;
                     end
                  end
                  default: begin
                     if (!blank) begin
                        do_open   = 1'b1;
                        word_next = quote ? WORD_QUOTED : WORD_PLAIN;
                     end
                  end
               endcase
            end
            KIND_ITEM: begin
               do_close  = hit;
               do_open   = hit;
               close_pos = pos_next - {13'd0, dlen};
               open_pos  = pos_next;
            end
            default: begin
               do_close = newline;
               do_open  = newline;
               open_pos = pos_next;
            end
         endcase
      end
   end

   assign close_hit = do_close && open1;

   always_comb begin
      first_start_in = first_start_ff;
      first_end_in   = first_end_ff;
      first_found_in = first_found_ff;
      last_start_in  = last_start_ff;
      last_end_in    = last_end_ff;
      last_found_in  = last_found_ff;
      if (close_hit && (cnt1 == {1'b0, cfg.first_rank})) begin
         first_start_in = start1;
         first_end_in   = close_pos;
         first_found_in = 1'b1;
      end
      if (close_hit && (cnt1 == {1'b0, cfg.last_rank})) begin
         last_start_in = start1;
         last_end_in   = close_pos;
         last_found_in = 1'b1;
      end
   end

   assign cnt2   = do_open ? cnt1 + 17'd1 : cnt1;
   assign start2 = do_open ? open_pos : start1;
   assign open2  = do_open || (open1 && !do_close);

   assign pos_in       = pos_next;
   assign cnt_in       = cnt2;
   assign cur_start_in = start2;
   assign open_in      = open2;
   assign word_in      = word_next;
   assign prev_nl_in   = newline;
   assign orphan_in    = orphan_ff ||
                         ((cfg.chunk_kind == KIND_CHAR) && (pos_ff == 16'd0) && cont);

   always_ff @(posedge clock) begin
      if (reset || finish) begin
         pos_ff         <= '0;
         cnt_ff         <= '0;
         cur_start_ff   <= '0;
         open_ff        <= 1'b0;
         orphan_ff      <= 1'b0;
         first_start_ff <= '0;
         first_end_ff   <= '0;
         first_found_ff <= 1'b0;
         last_start_ff  <= '0;
         last_end_ff    <= '0;
         last_found_ff  <= 1'b0;
         word_ff        <= WORD_BETWEEN;
         window_ff      <= '0;
         guard_ff       <= '0;
         prev_nl_ff     <= 1'b0;
      end else if (take_byte) begin
         pos_ff         <= pos_in;
         cnt_ff         <= cnt_in;
         cur_start_ff   <= cur_start_in;
         open_ff        <= open_in;
         orphan_ff      <= orphan_in;
         first_start_ff <= first_start_in;
         first_end_ff   <= first_end_in;
         first_found_ff <= first_found_in;
         last_start_ff  <= last_start_in;
         last_end_ff    <= last_end_in;
         last_found_ff  <= last_found_in;
         word_ff        <= word_in;
         window_ff      <= window_in;
         guard_ff       <= guard_in;
         prev_nl_ff     <= prev_nl_in;
      end
   end

   always_comb begin
      view.chunk_counter = cnt2;
      view.text_length   = pos_ff;
      view.first_start   = first_start_in;
      view.first_end     = first_end_in;
      view.first_found   = first_found_in;
      view.last_start    = last_start_in;
      view.last_end      = last_end_in;
      view.last_found    = last_found_in;
      view.lead_orphan   = orphan_ff;
      view.prev_newline  = prev_nl_ff;
   end

endmodule
`default_nettype wire

// ===== hdl/tcl_result.sv =====
// Result assembly at end of text and the output register of the result channel.
`default_nettype none
module tcl_result (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tcl_pkg::tcl_cfg_type  cfg,
   input  wire tcl_pkg::tcl_scan_type view,
   input  wire logic                  load,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output tcl_pkg::tcl_rsp_type       rsp_payload
);
   import tcl_pkg::*;

   logic                  valid_ff, valid_in;
   tcl_rsp_type           payload_ff, payload_in;
   tcl_rsp_type           result;
   logic [CountWidth-1:0] count_full;
   logic                  has_text;
   logic [PosWidth-1:0]   a_start, a_end, r_end_raw;
   logic                  a_found;

   assign has_text = (view.text_length != 16'd0);

   always_comb begin
      case (cfg.chunk_kind)
         KIND_CHAR: count_full = view.chunk_counter -
                       {16'd0, view.lead_orphan && (view.chunk_counter != 17'd0)};
         KIND_WORD: count_full = view.chunk_counter;
         KIND_ITEM: count_full = has_text ? view.chunk_counter : 17'd0;
         default:   count_full = !has_text ? 17'd0 :
                       view.chunk_counter -
                       {16'd0, view.prev_newline && (view.chunk_counter != 17'd0)};
      endcase
   end

   always_comb begin
      if (cfg.first_rank == 16'd0) begin
         a_start = '0;
         a_end   = '0;
         a_found = 1'b0;
      end else if (view.first_found) begin
         a_start = view.first_start;
         a_end   = view.first_end;
         a_found = 1'b1;
      end else begin
         a_start = view.text_length;
         a_end   = view.text_length;
         a_found = 1'b0;
      end
   end

   assign r_end_raw = view.last_found ? view.last_end : view.text_length;

   always_comb begin
      result.chunk_count  = count_full[16] ? 16'hFFFF : count_full[15:0];
      result.start_offset = a_start;
      result.found        = a_found;
      if ((cfg.last_rank != 16'd0) && (cfg.last_rank != cfg.first_rank)) begin
         result.end_offset = (r_end_raw < a_start) ? a_start : r_end_raw;
      end else begin
         result.end_offset = a_end;
      end
   end

   assign valid_in   = load || (valid_ff && !rsp_ready);
   assign payload_in = load ? result : payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule
`default_nettype wire
